FILE: hw/rtl/ocdq_pkg.sv
// Shared types and constants for the OFDM cell demapper with QPSK slicer.
package ocdq_pkg;

  localparam int unsigned BinW       = 16;
  localparam int unsigned CarrierW   = 8;
  localparam int unsigned SymbolW    = 6;
  localparam int unsigned FrameW     = 2;
  localparam int unsigned InDataW    = 32;
  localparam int unsigned OutDataW   = 24;
  localparam int unsigned OutUserW   = 2;

  localparam logic [CarrierW-1:0] CarrierLast = 8'd255;
  localparam logic [CarrierW-1:0] NullStart   = 8'd213;
  localparam logic [SymbolW-1:0]  SymbolLast  = 6'd39;
  localparam logic [SymbolW-1:0]  SdcLast     = 6'd4;

  // Cell class; CH_NONE marks a null or pilot bin that yields no result.
  typedef enum logic [1:0] {
    CH_MSC  = 2'd0,
    CH_FAC  = 2'd1,
    CH_SDC  = 2'd2,
    CH_NONE = 2'd3
  } chan_e;

  typedef struct packed {
    logic [FrameW-1:0]   frame;
    logic [SymbolW-1:0]  symbol;
    logic [CarrierW-1:0] carrier;
  } cnt_t;

endpackage

FILE: hw/rtl/ocdq_counter.sv
// Carrier, symbol and frame position counters.
module ocdq_counter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          advance_i,
  output ocdq_pkg::cnt_t cnt_o
);

  ocdq_pkg::cnt_t cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (advance_i) begin
      if (cnt_q.carrier == ocdq_pkg::CarrierLast) begin
        cnt_d.carrier = '0;
        if (cnt_q.symbol == ocdq_pkg::SymbolLast) begin
          cnt_d.symbol = '0;
          cnt_d.frame  = cnt_q.frame + 1'b1;
        end else begin
          cnt_d.symbol = cnt_q.symbol + 1'b1;
        end
      end else begin
        cnt_d.carrier = cnt_q.carrier + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule

FILE: hw/rtl/ocdq_classify.sv
// Cell classification of one bin position: null, pilot, FAC, SDC or MSC.
module ocdq_classify (
  input  ocdq_pkg::cnt_t cnt_i,
  output ocdq_pkg::chan_e chan_o
);

  logic [7:0] c;
  logic [5:0] s;
  logic [1:0] f;
  logic [3:0] c_lo;
  logic       is_null;
  logic       is_afs;
  logic       is_time;
  logic       is_gain;
  logic       is_fac;
  logic [3:0] gain_off;

  assign c    = cnt_i.carrier;
  assign s    = cnt_i.symbol;
  assign f    = cnt_i.frame;
  assign c_lo = c[3:0];

  assign is_null = (c >= ocdq_pkg::NullStart);
  assign is_afs  = (((f == 2'd0) && (s == 6'd4)) || ((f == 2'd3) && (s == 6'd39)))
                   && (c[1:0] == 2'd0);

  always_comb begin
    is_time = 1'b0;
    if ((c >= 8'd53  && c <= 8'd55)  || (c >= 8'd118 && c <= 8'd120) ||
        (c >= 8'd127 && c <= 8'd129) || (c >= 8'd146 && c <= 8'd148) ||
        (c == 8'd26)  || (c == 8'd27)  || (c == 8'd29)  || (c == 8'd74) ||
        (c == 8'd75)  || (c == 8'd173) || (c == 8'd174) || (c == 8'd185) ||
        (c == 8'd186)) begin
      is_time = (s == 6'd0);
    end
  end

  // Gain pilots sit on a comb of spacing 16 whose offset steps by 4 per symbol.
  always_comb begin
    case (s[1:0])
      2'd0:    gain_off = 4'd12;
      2'd1:    gain_off = 4'd0;
      2'd2:    gain_off = 4'd4;
      default: gain_off = 4'd8;
    endcase
  end
  assign is_gain = (c_lo == gain_off);

  always_comb begin
    is_fac = 1'b0;
    if (s >= 6'd5 && s <= 6'd26) begin
      case (s[1:0])
        2'd1: is_fac = (c_lo == 4'd12) && (c >= 8'd28) && (c <= 8'd188);
        2'd2: begin
          if (s == 6'd26) begin
            is_fac = (c == 8'd16) || (c == 8'd32) || (c == 8'd48);
          end else begin
            is_fac = ((c_lo == 4'd0) && (c >= 8'd16) && (c <= 8'd176)) || (c == 8'd196);
          end
        end
        2'd3:    is_fac = (c_lo == 4'd4) && (c >= 8'd20) && (c <= 8'd196);
        default: is_fac = (c_lo == 4'd8) && (c >= 8'd24) && (c <= 8'd184);
      endcase
    end
  end

  always_comb begin
    if (is_null || is_afs || is_time || is_gain) begin
      chan_o = ocdq_pkg::CH_NONE;
    end else if (is_fac) begin
      chan_o = ocdq_pkg::CH_FAC;
    end else if ((f == 2'd0) && (s <= ocdq_pkg::SdcLast)) begin
      chan_o = ocdq_pkg::CH_SDC;
    end else begin
      chan_o = ocdq_pkg::CH_MSC;
    end
  end

endmodule

FILE: hw/rtl/ofdm_cell_demapper_qpsk_slicer.sv
// Top level of the OFDM cell demapper with QPSK hard slicer.
// A data cell passes the input register and then the result register to the master side.
// Throughput: one bin per cycle via this register pair unless the master stalls.
// Null and pilot bins are consumed and yield no output transfer.
// Reset clears the carrier, symbol and frame counters and both valid flags.
module ofdm_cell_demapper_qpsk_slicer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [15:0] bin_re, [31:16] bin_im
  input  logic [ocdq_pkg::InDataW-1:0]     s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [0] real_negative, [1] imag_negative, [9:2] carrier_index,
  // [15:10] symbol_index, [17:16] frame_index, [23:18] zero
  output logic [ocdq_pkg::OutDataW-1:0]    m_axis_tdata_o,
  // [1:0] channel
  output logic [ocdq_pkg::OutUserW-1:0]    m_axis_tuser_o
);

  logic            in_xfer;
  logic            out_ready;
  logic            s1_move;
  ocdq_pkg::cnt_t  cnt;
  ocdq_pkg::chan_e s1_chan;

  logic            s1_valid_q, s1_valid_d;
  logic            s1_re_neg_q, s1_im_neg_q;
  ocdq_pkg::cnt_t  s1_cnt_q;

  logic            m_valid_q, m_valid_d;
  ocdq_pkg::chan_e m_chan_q;
  logic            m_re_neg_q, m_im_neg_q;
  ocdq_pkg::cnt_t  m_cnt_q;

  assign out_ready       = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_valid_q || out_ready;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign s1_move         = s1_valid_q && out_ready;

  ocdq_counter u_counter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (in_xfer),
    .cnt_o     (cnt)
  );

  ocdq_classify u_classify (
    .cnt_i  (s1_cnt_q),
    .chan_o (s1_chan)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (out_ready) begin
      s1_valid_d = 1'b0;
    end
    m_valid_d = m_valid_q;
    if (out_ready) begin
      m_valid_d = s1_move && (s1_chan != ocdq_pkg::CH_NONE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // Slicing keeps only the sign bits; zero counts as positive.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_re_neg_q <= s_axis_tdata_i[ocdq_pkg::BinW-1];
      s1_im_neg_q <= s_axis_tdata_i[2*ocdq_pkg::BinW-1];
      s1_cnt_q    <= cnt;
    end
    if (s1_move) begin
      m_chan_q   <= s1_chan;
      m_re_neg_q <= s1_re_neg_q;
      m_im_neg_q <= s1_im_neg_q;
      m_cnt_q    <= s1_cnt_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_chan_q;
  assign m_axis_tdata_o  = {6'd0, m_cnt_q.frame, m_cnt_q.symbol, m_cnt_q.carrier,
                            m_im_neg_q, m_re_neg_q};

  a_no_drop_class : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_chan_q != ocdq_pkg::CH_NONE))
    else $error("result carries the no-result class");

  a_no_null_carrier : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_cnt_q.carrier < ocdq_pkg::NullStart))
    else $error("result on a null carrier");

  a_sdc_region : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (m_chan_q == ocdq_pkg::CH_SDC)) |->
      ((m_cnt_q.frame == 2'd0) && (m_cnt_q.symbol <= ocdq_pkg::SdcLast)))
    else $error("SDC cell outside the first symbols of frame zero");

  a_counter_steps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (cnt.carrier != ocdq_pkg::CarrierLast)) |=>
      (cnt.carrier == $past(cnt.carrier) + 8'd1))
    else $error("carrier counter did not advance on input transfer");

endmodule

FILE: verif/tb_top.sv
// Testbench for the OFDM cell demapper: streams bins from reset and checks each data cell.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    ocdq_pkg::chan_e               chan;
    logic                          re_neg;
    logic                          im_neg;
    logic [ocdq_pkg::CarrierW-1:0] carrier;
    logic [ocdq_pkg::SymbolW-1:0]  symbol;
    logic [ocdq_pkg::FrameW-1:0]   frame;
  } data_cell_t;

  localparam int unsigned StreamBins = 1100;
  localparam int unsigned PhaseOneEnd = 430;
  localparam int unsigned PhaseTwoEnd = 770;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          bin_valid = 1'b0;
  logic                          bin_ready;
  logic [ocdq_pkg::InDataW-1:0]  bin_data = '0;
  logic                          cell_valid;
  logic                          cell_ready = 1'b0;
  logic [ocdq_pkg::OutDataW-1:0] cell_data;
  logic [ocdq_pkg::OutUserW-1:0] cell_user;

  // Position of the next bin, as the demapper should be tracking it.
  logic [ocdq_pkg::CarrierW-1:0] pos_carrier = '0;
  logic [ocdq_pkg::SymbolW-1:0]  pos_symbol = '0;
  logic [ocdq_pkg::FrameW-1:0]   pos_frame = '0;

  data_cell_t           expected_cells[$];
  int                   mismatches = 0;
  int                   bins_sent = 0;
  int                   tx_idle_pct = 0;
  int                   rx_idle_pct = 0;
  int                   hold_req = 0;
  int                   hold_left = 0;

  ofdm_cell_demapper_qpsk_slicer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (bin_valid),
    .s_axis_tready_o (bin_ready),
    .s_axis_tdata_i  (bin_data),
    .m_axis_tvalid_o (cell_valid),
    .m_axis_tready_i (cell_ready),
    .m_axis_tdata_o  (cell_data),
    .m_axis_tuser_o  (cell_user)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit is_time_pilot(input logic [ocdq_pkg::CarrierW-1:0] c);
    case (c)
      8'd26, 8'd27, 8'd29, 8'd74, 8'd75, 8'd173, 8'd174, 8'd185, 8'd186: return 1'b1;
      default: return (c >= 53 && c <= 55) || (c >= 118 && c <= 120) ||
                      (c >= 127 && c <= 129) || (c >= 146 && c <= 148);
    endcase
  endfunction

  function automatic bit is_fac_cell(input logic [ocdq_pkg::CarrierW-1:0] c,
                                     input logic [ocdq_pkg::SymbolW-1:0] s);
    if (s < 5 || s > 26) return 1'b0;
    case (s[1:0])
      2'd1: return c[3:0] == 4'd12 && c >= 28 && c <= 188;
      2'd2: begin
        // The last FAC symbol only carries the first three cells.
        if (s == 26) return c == 16 || c == 32 || c == 48;
        return (c[3:0] == 4'd0 && c >= 16 && c <= 176) || c == 196;
      end
      2'd3: return c[3:0] == 4'd4 && c >= 20 && c <= 196;
      default: return c[3:0] == 4'd8 && c >= 24 && c <= 184;
    endcase
  endfunction

  function automatic ocdq_pkg::chan_e cell_class(input logic [ocdq_pkg::CarrierW-1:0] c,
                                                 input logic [ocdq_pkg::SymbolW-1:0] s,
                                                 input logic [ocdq_pkg::FrameW-1:0] f);
    logic [3:0] gain_pos;
    // Gain pilots sit at 12, 0, 4, 8 modulo 16 for symbols 0..3 modulo 4.
    gain_pos = {s[1:0], 2'b00} + 4'd12;
    if (c >= ocdq_pkg::NullStart) return ocdq_pkg::CH_NONE;
    if (((f == 0 && s == ocdq_pkg::SdcLast) || (f == 3 && s == ocdq_pkg::SymbolLast)) &&
        c[1:0] == 2'b00)
      return ocdq_pkg::CH_NONE;
    if (s == 0 && is_time_pilot(c)) return ocdq_pkg::CH_NONE;
    if (c[3:0] == gain_pos) return ocdq_pkg::CH_NONE;
    if (is_fac_cell(c, s)) return ocdq_pkg::CH_FAC;
    if (f == 0 && s <= ocdq_pkg::SdcLast) return ocdq_pkg::CH_SDC;
    return ocdq_pkg::CH_MSC;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40)
      $display("ERROR at %0t ns: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // Predicts on every bin transfer and checks every cell transfer.
  always @(posedge clk_i) begin : cell_checker
    ocdq_pkg::chan_e cls;
    data_cell_t      want;
    if (rst_ni && bin_valid && bin_ready) begin
      cls = cell_class(pos_carrier, pos_symbol, pos_frame);
      if (cls != ocdq_pkg::CH_NONE)
        expected_cells.push_back(data_cell_t'{cls, bin_data[ocdq_pkg::BinW-1],
                                              bin_data[2*ocdq_pkg::BinW-1],
                                              pos_carrier, pos_symbol, pos_frame});
      if (pos_carrier == ocdq_pkg::CarrierLast) begin
        pos_carrier = '0;
        if (pos_symbol == ocdq_pkg::SymbolLast) begin
          pos_symbol = '0;
          pos_frame  = pos_frame + 1'b1;
        end else begin
          pos_symbol = pos_symbol + 1'b1;
        end
      end else begin
        pos_carrier = pos_carrier + 1'b1;
      end
    end
    if (rst_ni && cell_valid && cell_ready) begin
      if (expected_cells.size() == 0) begin
        report_mismatch("unexpected cell, carrier", cell_data[9:2], -1);
      end else begin
        want = expected_cells.pop_front();
        if (cell_user != want.chan) report_mismatch("channel", cell_user, want.chan);
        if (cell_data[0] != want.re_neg)
          report_mismatch("real_negative", cell_data[0], want.re_neg);
        if (cell_data[1] != want.im_neg)
          report_mismatch("imag_negative", cell_data[1], want.im_neg);
        if (cell_data[9:2] != want.carrier)
          report_mismatch("carrier_index", cell_data[9:2], want.carrier);
        if (cell_data[15:10] != want.symbol)
          report_mismatch("symbol_index", cell_data[15:10], want.symbol);
        if (cell_data[17:16] != want.frame)
          report_mismatch("frame_index", cell_data[17:16], want.frame);
      end
    end
  end

  // Result side: random stalls, plus long hold-offs on request.
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left  <= hold_req - 1;
      hold_req   <= 0;
      cell_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      cell_ready <= 1'b0;
    end else begin
      cell_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_bin(input logic [ocdq_pkg::BinW-1:0] re,
                          input logic [ocdq_pkg::BinW-1:0] im);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      bin_valid <= 1'b0;
      @(posedge clk_i);
    end
    bin_valid <= 1'b1;
    bin_data  <= {im, re};
    do @(posedge clk_i); while (!bin_ready);
    bins_sent++;
  endtask

  // Leans toward the sign boundary and the zero tie, otherwise uniform.
  function automatic logic [ocdq_pkg::BinW-1:0] pick_component();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic wait_for_cells();
    bin_valid <= 1'b0;
    do @(posedge clk_i); while (expected_cells.size() != 0);
  endtask

  // Symbol 0 of frame 0: SDC cells, two gain pilots and the first time pilots.
  task automatic test_slicer_extremes();
    logic [ocdq_pkg::BinW-1:0] vals[6];
    vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h4000};
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < 30; i++) send_bin(vals[i % 6], vals[(i + i / 6) % 6]);
    wait_for_cells();
  endtask

  // The sink holds off long enough for the pipeline to fill and stall the bins.
  task automatic test_output_stall();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req <= 300;
    for (int i = 0; i < 60; i++) send_bin(pick_component(), pick_component());
    wait_for_cells();
  endtask

  // Random bins under changing stall patterns, reaching the AFS pilots of symbol 4.
  task automatic test_random_stream();
    while (bins_sent < StreamBins) begin
      if (bins_sent < PhaseOneEnd) begin
        tx_idle_pct = 29;
        rx_idle_pct = 49;
      end else if (bins_sent < PhaseTwoEnd) begin
        tx_idle_pct = 49;
        rx_idle_pct = 29;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_bin(pick_component(), pick_component());
    end
    wait_for_cells();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_slicer_extremes();
    test_output_stall();
    test_random_stream();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_cells.size() == 0) begin
      $display("ofdm_cell_demapper_qpsk_slicer: match");
    end else begin
      $display("ofdm_cell_demapper_qpsk_slicer: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("ofdm_cell_demapper_qpsk_slicer: mismatch");
    $finish;
  end

endmodule
